### sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

### sv/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types and constants of the tick-driven i2c register master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

    localparam int MAX_BYTES_DEF = 8;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_LOAD  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ADDR_W = 2'd0,
        KIND_REG    = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_ADDR_R = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NACK_ADDR = 2'd1,
        ST_NACK_REG  = 2'd2,
        ST_NACK_DATA = 2'd3
    } status_t;

    // configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_PHASE_TICKS    = 1'b1;

    localparam logic [6:0]  DEV_ADDR_RST    = 7'd104;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd100;

    typedef enum logic [15:0] {
        PH_IDLE      = 16'h0001,
        PH_START     = 16'h0002,
        PH_TX_LOW    = 16'h0004,
        PH_TX_HIGH   = 16'h0008,
        PH_ACK_LOW   = 16'h0010,
        PH_ACK_HIGH  = 16'h0020,
        PH_RS_LOW    = 16'h0040,
        PH_RS_HIGH   = 16'h0080,
        PH_RS_START  = 16'h0100,
        PH_RX_LOW    = 16'h0200,
        PH_RX_HIGH   = 16'h0400,
        PH_MACK_LOW  = 16'h0800,
        PH_MACK_HIGH = 16'h1000,
        PH_STOP_LOW  = 16'h2000,
        PH_STOP_HIGH = 16'h4000,
        PH_STOP_REL  = 16'h8000
    } phase_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] register_address;
        logic [3:0] byte_count;
        logic [2:0] buffer_index;
        logic [7:0] write_byte;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic       done_res;
        logic [1:0] status;
    } res_t;

endpackage

### sv/i2crm_wbuf.sv
// ----------------------------------------------------------------------------
// i2crm_wbuf
// Write data buffer: one write port, one registered read port with
// write-through when both hit the same entry.
// ----------------------------------------------------------------------------
module i2crm_wbuf
    import i2crm_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF,
    localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [MAX_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/i2crm_seq.sv
// ----------------------------------------------------------------------------
// i2crm_seq
// Bus sequencer: holds the transaction state and works out one tick per
// accepted item, giving the bus levels and the per-tick result.
// ----------------------------------------------------------------------------
module i2crm_seq
    import i2crm_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  item_t       item,
    input  logic [6:0]  device_address,
    input  logic [15:0] phase_ticks,
    output res_t        res
);

    localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    phase_t             phase_reg, phase_next;
    logic [15:0]        tc_reg, tc_next;
    logic [3:0]         bitc_reg, bitc_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [7:0]         sh_reg, sh_next;
    logic               is_read_reg, is_read_next;
    logic [7:0]         sreg_reg, sreg_next;
    kind_t              kind_reg, kind_next;
    logic [CNT_W-1:0]   slot_reg, slot_next;
    logic [1:0]         pend_reg, pend_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   cur_addr;
    logic [7:0]         rd_data;
    logic [7:0]         buf_val;
    logic [15:0]        limit;
    op_t                op;

    assign op      = op_t'(item.operation);
    assign limit   = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    assign wr_addr = IDX_W'(item.buffer_index);
    assign wr_en   = step && (op == OP_LOAD)
                     && ({29'd0, item.buffer_index} < 32'(MAX_BYTES));

    // entry that the next data send will take
    assign cur_addr = (kind_reg == KIND_DATA) ? IDX_W'(slot_reg + CNT_W'(1)) : '0;
    assign rd_addr  = !step ? cur_addr
                    : ((kind_next == KIND_DATA) ? IDX_W'(slot_next + CNT_W'(1)) : '0);
    assign buf_val  = (wr_en && (wr_addr == cur_addr)) ? item.write_byte : rd_data;

    i2crm_wbuf #(
        .MAX_BYTES (MAX_BYTES)
    ) u_wbuf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.write_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        phase_t      ph;
        logic        msb;
        logic        nack_lvl;
        logic [15:0] tc_inc;
        logic [7:0]  cnt8;

        phase_next   = phase_reg;
        tc_next      = tc_reg;
        bitc_next    = bitc_reg;
        left_next    = left_reg;
        sh_next      = sh_reg;
        is_read_next = is_read_reg;
        sreg_next    = sreg_reg;
        kind_next    = kind_reg;
        slot_next    = slot_reg;
        pend_next    = pend_reg;
        res          = '0;
        res.scl_level = 1'b1;
        res.sda_level = 1'b1;
        cnt8         = {4'd0, item.byte_count};

        if ((phase_reg == PH_IDLE) && ((op == OP_WRITE) || (op == OP_READ)))
        begin
            if (cnt8 == 8'd0)
            begin
                cnt8 = 8'd1;
            end
            if (cnt8 > 8'(MAX_BYTES))
            begin
                cnt8 = 8'(MAX_BYTES);
            end
            is_read_next = (op == OP_READ);
            sreg_next    = item.register_address;
            left_next    = CNT_W'(cnt8);
            slot_next    = '0;
            pend_next    = ST_OK;
            tc_next      = '0;
            phase_next   = PH_START;
        end

        ph       = phase_next;
        msb      = sh_next[7];
        nack_lvl = (left_next == CNT_W'(1));
        tc_inc   = tc_next + 16'd1;

        if (ph != PH_IDLE)
        begin
            res.busy_res = 1'b1;
            case (ph)
                PH_START, PH_RS_START:
                begin
                    res.scl_level = 1'b1;
                    res.sda_level = 1'b0;
                end
                PH_TX_LOW:
                begin
                    res.scl_level = 1'b0;
                    res.sda_level = msb;
                end
                PH_TX_HIGH:
                begin
                    res.scl_level = 1'b1;
                    res.sda_level = msb;
                end
                PH_ACK_LOW, PH_RS_LOW, PH_RX_LOW:
                begin
                    res.scl_level = 1'b0;
                    res.sda_level = 1'b1;
                end
                PH_MACK_LOW:
                begin
                    res.scl_level = 1'b0;
                    res.sda_level = nack_lvl;
                end
                PH_MACK_HIGH:
                begin
                    res.scl_level = 1'b1;
                    res.sda_level = nack_lvl;
                end
                PH_STOP_LOW:
                begin
                    res.scl_level = 1'b0;
                    res.sda_level = 1'b0;
                end
                PH_STOP_HIGH:
                begin
                    res.scl_level = 1'b1;
                    res.sda_level = 1'b0;
                end
                default:
                begin
                    res.scl_level = 1'b1;
                    res.sda_level = 1'b1;
                end
            endcase

            if (tc_inc >= limit)
            begin
                tc_next = '0;
                case (ph)
                    PH_START:
                    begin
                        sh_next    = {device_address, 1'b0};
                        bitc_next  = '0;
                        kind_next  = KIND_ADDR_W;
                        phase_next = PH_TX_LOW;
                    end
                    PH_TX_LOW:
                    begin
                        phase_next = PH_TX_HIGH;
                    end
                    PH_TX_HIGH:
                    begin
                        sh_next    = {sh_next[6:0], 1'b0};
                        bitc_next  = bitc_next + 4'd1;
                        phase_next = (bitc_next >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
                    end
                    PH_ACK_LOW:
                    begin
                        phase_next = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH:
                    begin
                        if (item.sda_in)
                        begin
                            // released line means the target did not acknowledge
                            case (kind_next)
                                KIND_REG:  pend_next = ST_NACK_REG;
                                KIND_DATA: pend_next = ST_NACK_DATA;
                                default:   pend_next = ST_NACK_ADDR;
                            endcase
                            phase_next = PH_STOP_LOW;
                        end
                        else
                        begin
                            case (kind_next)
                                KIND_ADDR_W:
                                begin
                                    sh_next    = sreg_next;
                                    bitc_next  = '0;
                                    kind_next  = KIND_REG;
                                    phase_next = PH_TX_LOW;
                                end
                                KIND_REG:
                                begin
                                    if (is_read_next)
                                    begin
                                        phase_next = PH_RS_LOW;
                                    end
                                    else
                                    begin
                                        slot_next  = '0;
                                        sh_next    = buf_val;
                                        bitc_next  = '0;
                                        kind_next  = KIND_DATA;
                                        phase_next = PH_TX_LOW;
                                    end
                                end
                                KIND_DATA:
                                begin
                                    if (left_next != '0)
                                    begin
                                        left_next = left_next - CNT_W'(1);
                                    end
                                    slot_next = slot_next + CNT_W'(1);
                                    if ((left_next == '0)
                                        || (slot_next >= CNT_W'(MAX_BYTES)))
                                    begin
                                        pend_next  = ST_OK;
                                        phase_next = PH_STOP_LOW;
                                    end
                                    else
                                    begin
                                        sh_next    = buf_val;
                                        bitc_next  = '0;
                                        phase_next = PH_TX_LOW;
                                    end
                                end
                                default:
                                begin
                                    sh_next    = '0;
                                    bitc_next  = '0;
                                    phase_next = PH_RX_LOW;
                                end
                            endcase
                        end
                    end
                    PH_RS_LOW:
                    begin
                        phase_next = PH_RS_HIGH;
                    end
                    PH_RS_HIGH:
                    begin
                        phase_next = PH_RS_START;
                    end
                    PH_RS_START:
                    begin
                        sh_next    = {device_address, 1'b1};
                        bitc_next  = '0;
                        kind_next  = KIND_ADDR_R;
                        phase_next = PH_TX_LOW;
                    end
                    PH_RX_LOW:
                    begin
                        phase_next = PH_RX_HIGH;
                    end
                    PH_RX_HIGH:
                    begin
                        sh_next   = {sh_next[6:0], item.sda_in};
                        bitc_next = bitc_next + 4'd1;
                        if (bitc_next >= 4'd8)
                        begin
                            res.read_byte  = sh_next;
                            res.read_valid = 1'b1;
                            res.read_last  = nack_lvl;
                            phase_next     = PH_MACK_LOW;
                        end
                        else
                        begin
                            phase_next = PH_RX_LOW;
                        end
                    end
                    PH_MACK_LOW:
                    begin
                        phase_next = PH_MACK_HIGH;
                    end
                    PH_MACK_HIGH:
                    begin
                        if (left_next != '0)
                        begin
                            left_next = left_next - CNT_W'(1);
                        end
                        if (left_next == '0)
                        begin
                            pend_next  = ST_OK;
                            phase_next = PH_STOP_LOW;
                        end
                        else
                        begin
                            sh_next    = '0;
                            bitc_next  = '0;
                            phase_next = PH_RX_LOW;
                        end
                    end
                    PH_STOP_LOW:
                    begin
                        phase_next = PH_STOP_HIGH;
                    end
                    PH_STOP_HIGH:
                    begin
                        phase_next = PH_STOP_REL;
                    end
                    default:
                    begin
                        res.done_res = 1'b1;
                        res.status   = pend_next;
                        phase_next   = PH_IDLE;
                    end
                endcase
            end
            else
            begin
                tc_next = tc_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tc_reg      <= '0;
            bitc_reg    <= '0;
            left_reg    <= '0;
            sh_reg      <= '0;
            is_read_reg <= 1'b0;
            sreg_reg    <= '0;
            kind_reg    <= KIND_ADDR_W;
            slot_reg    <= '0;
            pend_reg    <= ST_OK;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            tc_reg      <= tc_next;
            bitc_reg    <= bitc_next;
            left_reg    <= left_next;
            sh_reg      <= sh_next;
            is_read_reg <= is_read_next;
            sreg_reg    <= sreg_next;
            kind_reg    <= kind_next;
            slot_reg    <= slot_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

### sv/i2c_register_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_register_master_unit
// Tick-driven i2c master for register writes and register reads.
// ----------------------------------------------------------------------------
// Usage:
// Each input item is one bus tick and carries an operation (tick, start
// write, start read, load a write buffer byte) and the sampled sda level.
// Every item gives exactly one result item: the scl/sda levels for that
// tick, busy, any completed read byte and, at the end, done with status.
// The input channel (in_valid/in_stall) feeds an input register; the item
// is worked out in one pass and lands in the result register. One item is
// taken every cycle while the result channel (out_valid/out_stall) is not
// stalled. While out_stall holds a full result register, the input register
// holds its item and in_stall rises; nothing is dropped. Configuration
// (device_address, phase_ticks) is written on cfg_valid/cfg_ready, ready
// always high. Reset empties both registers, returns the bus to idle with
// both lines released and loads device address 104 and 100 ticks per bus
// phase.
// ----------------------------------------------------------------------------
module i2c_register_master_unit
    import i2crm_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  register_address,
    input  logic [3:0]  byte_count,
    input  logic [2:0]  buffer_index,
    input  logic [7:0]  write_byte,
    input  logic        sda_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_level,
    output logic        sda_level,
    output logic        busy_res,
    output logic [7:0]  read_byte,
    output logic        read_valid,
    output logic        read_last,
    output logic        done_res,
    output logic [1:0]  status,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    item_t       in_reg;
    logic        in_valid_reg;
    res_t        res;
    res_t        out_reg;
    logic        out_valid_reg;
    logic        advance;
    logic [6:0]  dev_addr_reg;
    logic [15:0] phase_ticks_reg;

    // the held item moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg    <= DEV_ADDR_RST;
            phase_ticks_reg <= PHASE_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: dev_addr_reg    <= cfg_data[6:0];
                CFG_PHASE_TICKS:    phase_ticks_reg <= cfg_data;
                default:            dev_addr_reg    <= dev_addr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_reg.operation        <= operation;
            in_reg.register_address <= register_address;
            in_reg.byte_count       <= byte_count;
            in_reg.buffer_index     <= buffer_index;
            in_reg.write_byte       <= write_byte;
            in_reg.sda_in           <= sda_in;
        end
    end

    i2crm_seq #(
        .MAX_BYTES (MAX_BYTES)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .item           (in_reg),
        .device_address (dev_addr_reg),
        .phase_ticks    (phase_ticks_reg),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scl_level  = out_reg.scl_level;
    assign sda_level  = out_reg.sda_level;
    assign busy_res   = out_reg.busy_res;
    assign read_byte  = out_reg.read_byte;
    assign read_valid = out_reg.read_valid;
    assign read_last  = out_reg.read_last;
    assign done_res   = out_reg.done_res;
    assign status     = out_reg.status;

endmodule

### sv/i2crm_checker.sv
// ----------------------------------------------------------------------------
// i2crm_checker
// Port-level checks of the i2c register master, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2crm_checker
    import i2crm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  operation,
    input logic [7:0]  register_address,
    input logic [3:0]  byte_count,
    input logic [2:0]  buffer_index,
    input logic [7:0]  write_byte,
    input logic        sda_in,
    input logic        out_valid,
    input logic        out_stall,
    input logic        scl_level,
    input logic        sda_level,
    input logic        busy_res,
    input logic [7:0]  read_byte,
    input logic        read_valid,
    input logic        read_last,
    input logic        done_res,
    input logic [1:0]  status,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        cfg_index,
    input logic [15:0] cfg_data
);

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    // idle ticks release both lines and carry no event
    `ASSERT_IMPLY(a_idle_lines, clk, rst_n, out_valid && !busy_res, scl_level && sda_level && !done_res && !read_valid)
    // a read byte completes at the end of a clock-high phase, never together with done
    `ASSERT_IMPLY(a_read_phase, clk, rst_n, out_valid && read_valid, busy_res && scl_level && !done_res)
    // a nack status only comes with done
    `ASSERT_IMPLY(a_status_done, clk, rst_n, out_valid && (status != ST_OK), done_res)

endmodule

bind i2c_register_master_unit i2crm_checker u_i2crm_checker (.*);
